// ===== rtl/sbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sbc_pkg;
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int MARGIN_BITS    = 16;
    localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 16'd66;

    typedef enum logic [2:0] {
        OC_MISS    = 3'd0,
        OC_NOREACH = 3'd1,
        OC_CLAMP_X = 3'd2,
        OC_CLAMP_Y = 3'd3,
        OC_CLAMP_Z = 3'd4,
        OC_REVERSE = 3'd5
    } outcome_t;

    // per-axis classification handed from front to back
    typedef enum logic [1:0] {
        AX_OVERLAP = 2'd0,
        AX_POS     = 2'd1,
        AX_NEG     = 2'd2,
        AX_NONE    = 2'd3
    } axis_kind_t;
endpackage
`default_nettype wire

// ===== rtl/sbc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// front: holds the mover box, classifies a test item per axis and forms the
// divider operands (numerator gap and denominator |move|)
module sbc_front
    import sbc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_op,
    input  wire logic signed [COORD_BITS-1:0] in_lo [3],
    input  wire logic signed [COORD_BITS-1:0] in_hi [3],
    input  wire logic signed [COORD_BITS-1:0] in_mv [3],
    output logic                              test_valid,
    output logic                              test_miss,
    output axis_kind_t                        test_kind [3],
    output logic [COORD_BITS:0]               test_gap [3],
    output logic [COORD_BITS:0]               test_den [3],
    output logic signed [COORD_BITS-1:0]      test_mv [3]
);
    localparam int W = COORD_BITS + 1;
    logic signed [COORD_BITS-1:0] lo_reg [3];
    logic signed [COORD_BITS-1:0] hi_reg [3];
    logic miss;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= {1'b0, {(COORD_BITS-1){1'b1}}};
                hi_reg[i] <= {1'b1, {(COORD_BITS-1){1'b0}}};
            end
        end
        else if (in_valid && !in_op)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= in_lo[i];
                hi_reg[i] <= in_hi[i];
            end
        end
    end

    always_comb
    begin
        logic signed [W:0] lo, hi, olo, ohi, m, lom, him, smin, smax;
        miss = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            lo  = (W+1)'(lo_reg[i]);
            hi  = (W+1)'(hi_reg[i]);
            olo = (W+1)'(in_lo[i]);
            ohi = (W+1)'(in_hi[i]);
            m   = (W+1)'(in_mv[i]);
            lom = lo + m;
            him = hi + m;
            smin = (lom < lo) ? lom : lo;
            smin = (him < smin) ? him : smin;
            smax = (lom > hi) ? lom : hi;
            smax = (him > smax) ? him : smax;
            if (!(smax > olo && smin < ohi))
                miss = 1'b1;
            test_mv[i] = in_mv[i];
            if (hi > olo && lo < ohi)
            begin
                test_kind[i] = AX_OVERLAP;
                test_gap[i]  = '0;
                test_den[i]  = '0;
            end
            else if (hi <= olo && him > olo)
            begin
                test_kind[i] = AX_POS;
                test_gap[i]  = W'(olo - hi);
                test_den[i]  = W'(m);
            end
            else if (lo >= ohi && lom < ohi)
            begin
                test_kind[i] = AX_NEG;
                test_gap[i]  = W'(lo - ohi);
                test_den[i]  = W'(-m);
            end
            else
            begin
                test_kind[i] = AX_NONE;
                test_gap[i]  = '0;
                test_den[i]  = '0;
            end
        end
        test_miss  = miss;
        test_valid = in_valid && in_op;
    end
endmodule
`default_nettype wire

// ===== rtl/sbc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// back: pipelined restoring divider (one quotient bit per stage, three axes
// in parallel), then winner pick, multiply stage and margin clamp
module sbc_back
    import sbc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [MARGIN_BITS-1:0]       margin,
    input  wire logic                         in_valid,
    input  wire logic                         in_miss,
    input  wire axis_kind_t                   in_kind [3],
    input  wire logic [COORD_BITS:0]          in_gap [3],
    input  wire logic [COORD_BITS:0]          in_den [3],
    input  wire logic signed [COORD_BITS-1:0] in_mv [3],
    input  wire logic                         stall,
    output logic                              out_valid,
    output logic signed [COORD_BITS-1:0]      out_mv [3],
    output outcome_t                          out_code
);
    localparam int W  = COORD_BITS + 1;
    localparam int S  = FRAC_BITS;
    localparam int TW = FRAC_BITS + 1;
    localparam int PW = COORD_BITS + TW;

    // divider pipeline, stage s holds the item after s quotient bits
    logic               dv_reg   [1:S];
    logic               dm_reg   [1:S];
    axis_kind_t         dk_reg   [1:S][3];
    logic [W:0]         dr_reg   [1:S][3];
    logic [W-1:0]       dd_reg   [1:S][3];
    logic [S-1:0]       dq_reg   [1:S][3];
    logic signed [COORD_BITS-1:0] dmv_reg [1:S][3];

    for (genvar s = 0; s < S; s++)
    begin : g_div
        logic                         src_v;
        logic                         src_m;
        axis_kind_t                   src_k [3];
        logic [W:0]                   src_r [3];
        logic [W-1:0]                 src_d [3];
        logic [S-1:0]                 src_q [3];
        logic signed [COORD_BITS-1:0] src_mv [3];

        if (s == 0)
        begin : g_src
            always_comb
            begin
                src_v = in_valid;
                src_m = in_miss;
                for (int a = 0; a < 3; a++)
                begin
                    src_k[a]  = in_kind[a];
                    src_r[a]  = {1'b0, in_gap[a]};
                    src_d[a]  = in_den[a];
                    src_q[a]  = '0;
                    src_mv[a] = in_mv[a];
                end
            end
        end
        else
        begin : g_src
            always_comb
            begin
                src_v = dv_reg[s];
                src_m = dm_reg[s];
                for (int a = 0; a < 3; a++)
                begin
                    src_k[a]  = dk_reg[s][a];
                    src_r[a]  = dr_reg[s][a];
                    src_d[a]  = dd_reg[s][a];
                    src_q[a]  = dq_reg[s][a];
                    src_mv[a] = dmv_reg[s][a];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[s+1] <= 1'b0;
            else if (!stall)
                dv_reg[s+1] <= src_v;
        end
        always_ff @(posedge clk)
        begin
            logic [W:0] sh;
            if (!stall)
            begin
                dm_reg[s+1] <= src_m;
                for (int a = 0; a < 3; a++)
                begin
                    sh = {src_r[a][W-1:0], 1'b0};
                    dk_reg[s+1][a]  <= src_k[a];
                    dd_reg[s+1][a]  <= src_d[a];
                    dmv_reg[s+1][a] <= src_mv[a];
                    if (sh >= {1'b0, src_d[a]})
                    begin
                        dr_reg[s+1][a] <= sh - {1'b0, src_d[a]};
                        dq_reg[s+1][a] <= {src_q[a][S-2:0], 1'b1};
                    end
                    else
                    begin
                        dr_reg[s+1][a] <= sh;
                        dq_reg[s+1][a] <= {src_q[a][S-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // winner pick and magnitude product
    logic                         pv_reg;
    outcome_t                     pc_reg;
    logic [1:0]                   pw_reg;
    logic [PW-1:0]                pp_reg;
    logic signed [COORD_BITS-1:0] pmv_reg [3];
    logic [1:0]                   win;
    logic                         found;
    outcome_t                     code;
    logic [COORD_BITS-1:0]        mag;
    logic [PW-1:0]                prod;

    always_comb
    begin
        logic nr;
        logic [TW-1:0] t [3];
        nr = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            if (dk_reg[S][a] == AX_NONE)
                nr = 1'b1;
            t[a] = (dk_reg[S][a] == AX_OVERLAP) ? '0 : {1'b0, dq_reg[S][a]};
        end
        found = 1'b0;
        win = 2'd0;
        for (int a = 0; a < 3; a++)
        begin
            if (!found && dk_reg[S][a] != AX_OVERLAP
                && (dk_reg[S][0] == AX_OVERLAP || t[a] >= t[0])
                && (dk_reg[S][1] == AX_OVERLAP || t[a] >= t[1])
                && (dk_reg[S][2] == AX_OVERLAP || t[a] >= t[2]))
            begin
                found = 1'b1;
                win = 2'(a);
            end
        end
        if (dm_reg[S])
            code = OC_MISS;
        else if (nr)
            code = OC_NOREACH;
        else if (!found)
            code = OC_REVERSE;
        else
            unique case (win)
                2'd0: code = OC_CLAMP_X;
                2'd1: code = OC_CLAMP_Y;
                default: code = OC_CLAMP_Z;
            endcase
        mag = dmv_reg[S][win][COORD_BITS-1] ? COORD_BITS'(-dmv_reg[S][win])
                                            : COORD_BITS'(dmv_reg[S][win]);
        prod = PW'(mag) * PW'(t[win]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (!stall)
            pv_reg <= dv_reg[S];
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            pc_reg  <= code;
            pw_reg  <= win;
            pp_reg  <= prod;
            pmv_reg <= dmv_reg[S];
        end
    end

    // margin clamp and sign restore
    always_comb
    begin
        logic [PW-FRAC_BITS-1:0] sc;
        logic [PW-FRAC_BITS-1:0] r;
        logic signed [COORD_BITS-1:0] m;
        sc = pp_reg[PW-1:FRAC_BITS];
        r = (sc > (PW-FRAC_BITS)'(margin)) ? sc - (PW-FRAC_BITS)'(margin) : '0;
        m = pmv_reg[pw_reg];
        out_valid = pv_reg;
        out_code  = pc_reg;
        for (int a = 0; a < 3; a++)
        begin
            if (pc_reg == OC_REVERSE)
                out_mv[a] = -pmv_reg[a];
            else
                out_mv[a] = pmv_reg[a];
        end
        if (pc_reg == OC_CLAMP_X || pc_reg == OC_CLAMP_Y || pc_reg == OC_CLAMP_Z)
        begin
            if (m[COORD_BITS-1])
                out_mv[pw_reg] = -COORD_BITS'(r);
            else if (m != '0)
                out_mv[pw_reg] = COORD_BITS'(r);
            else
                out_mv[pw_reg] = '0;
        end
    end

`ifndef SYNTHESIS
    a_clamp_axis: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg && pc_reg == OC_CLAMP_X |-> pw_reg == 2'd0)
        else $error("clamp axis mismatch");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stall && pv_reg |=> pv_reg && $stable(pp_reg))
        else $error("result moved under stall");
    a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
        !stall && dv_reg[S] && dm_reg[S] |=> pc_reg == OC_MISS)
        else $error("miss lost");
`endif
endmodule
`default_nettype wire

// ===== rtl/sbc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// result queue; raises afull once it holds DEPTH - 1 items
module sbc_fifo
    import sbc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int DEPTH = 4
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr,
    input  wire logic signed [COORD_BITS-1:0] wr_mv [3],
    input  wire outcome_t                     wr_code,
    input  wire logic                         rd,
    output logic                              empty,
    output logic                              afull,
    output logic signed [COORD_BITS-1:0]      rd_mv [3],
    output outcome_t                          rd_code
);
    localparam int AW = $clog2(DEPTH);
    logic signed [COORD_BITS-1:0] mv_reg [DEPTH][3];
    outcome_t code_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mv_reg[wp_reg] <= wr_mv;
            code_reg[wp_reg] <= wr_code;
        end
    end

    assign empty   = (cnt_reg == '0);
    assign afull   = (cnt_reg >= (AW+1)'(DEPTH - 1));
    assign rd_mv   = mv_reg[rp_reg];
    assign rd_code = code_reg[rp_reg];
endmodule
`default_nettype wire

// ===== rtl/swept_box_collision_clamp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Swept box collision clamp. Load items (op 0) store the moving box and give
// no result; test items (op 1) give one result each. One item is accepted per
// cycle unless the pipe stalls; the restoring divider on the test path forms
// one time bit per stage. The pipe stalls as a whole when the result queue is
// nearly full and pop is held low.
module swept_box_collision_clamp
    import sbc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         op,
    input  wire logic signed [COORD_BITS-1:0] box_lo_x,
    input  wire logic signed [COORD_BITS-1:0] box_lo_y,
    input  wire logic signed [COORD_BITS-1:0] box_lo_z,
    input  wire logic signed [COORD_BITS-1:0] box_hi_x,
    input  wire logic signed [COORD_BITS-1:0] box_hi_y,
    input  wire logic signed [COORD_BITS-1:0] box_hi_z,
    input  wire logic signed [COORD_BITS-1:0] move_x,
    input  wire logic signed [COORD_BITS-1:0] move_y,
    input  wire logic signed [COORD_BITS-1:0] move_z,
    input  wire logic                         cfg_we,
    input  wire logic [MARGIN_BITS-1:0]       cfg_data,
    output logic                              empty,
    input  wire logic                         pop,
    output logic signed [COORD_BITS-1:0]      out_x,
    output logic signed [COORD_BITS-1:0]      out_y,
    output logic signed [COORD_BITS-1:0]      out_z,
    output logic [2:0]                        outcome
);
    logic [MARGIN_BITS-1:0] margin_reg;
    logic signed [COORD_BITS-1:0] lo [3], hi [3], mv [3];
    logic tv, tm, bv, stall, afull, qempty, rd;
    axis_kind_t tk [3];
    logic [COORD_BITS:0] tg [3], td [3];
    logic signed [COORD_BITS-1:0] bmv [3], qmv [3];
    outcome_t bc, qc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            margin_reg <= MARGIN_RESET;
        else if (cfg_we)
            margin_reg <= cfg_data;
    end

    assign lo = '{box_lo_x, box_lo_y, box_lo_z};
    assign hi = '{box_hi_x, box_hi_y, box_hi_z};
    assign mv = '{move_x, move_y, move_z};

    // stall the whole pipe only when the queue is nearly full and no pop frees an entry
    assign stall = afull && !pop;
    assign full  = stall;
    assign rd    = pop && !qempty;

    sbc_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(push && !full), .in_op(op),
        .in_lo(lo), .in_hi(hi), .in_mv(mv),
        .test_valid(tv), .test_miss(tm), .test_kind(tk),
        .test_gap(tg), .test_den(td), .test_mv(bmv)
    );

    logic signed [COORD_BITS-1:0] pmv [3];

    sbc_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .margin(margin_reg),
        .in_valid(tv), .in_miss(tm), .in_kind(tk), .in_gap(tg),
        .in_den(td), .in_mv(bmv), .stall(stall),
        .out_valid(bv), .out_mv(pmv), .out_code(bc)
    );

    sbc_fifo #(.COORD_BITS(COORD_BITS), .DEPTH(4)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr(bv && !stall), .wr_mv(pmv), .wr_code(bc),
        .rd(rd), .empty(qempty), .afull(afull),
        .rd_mv(qmv), .rd_code(qc)
    );

    assign empty   = qempty;
    assign out_x   = qmv[0];
    assign out_y   = qmv[1];
    assign out_z   = qmv[2];
    assign outcome = 3'(qc);

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !rd)
        else $error("read from empty queue");
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> outcome <= 3'd5)
        else $error("bad outcome");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> margin_reg == $past(cfg_data))
        else $error("margin not written");
`endif
endmodule
`default_nettype wire
